FILE: rtl/fpfc_pkg.sv
// Shared types, constants and helper functions of the flame position flow controller.
// Depends on nothing; the core, the multiplier and the divider import it.
package fpfc_pkg;

  localparam int WINDOW     = 16;
  localparam int WIN_DEPTH  = WINDOW + 1;
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int Q_FRAC     = 16;
  localparam int DIV_STEPS  = 32 + Q_FRAC;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int WIDE_W     = 40;

  typedef logic signed [31:0]       q_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam q_t    Q_ONE  = 32'sd65536;
  localparam q_t    Q_MAX  = 32'sh7FFF_FFFF;
  localparam q_t    Q_MIN  = 32'sh8000_0000;
  localparam wide_t W_MAX  = 40'sd2147483647;
  localparam wide_t W_MIN  = -40'sd2147483648;

  localparam logic [1:0] LAW_NONE   = 2'd0;
  localparam logic [1:0] LAW_LINEAR = 2'd1;
  localparam logic [1:0] LAW_QUAD1  = 2'd2;
  localparam logic [1:0] LAW_QUAD2  = 2'd3;

  localparam logic [1:0]  LAW_RESET    = LAW_LINEAR;
  localparam logic [30:0] TAU_RESET    = 31'd65536;
  localparam q_t          TARGET_RESET = 32'sd0;
  localparam logic [30:0] SCALE_RESET  = 31'd65536;
  localparam logic [30:0] CHANGE_RESET = 31'd6554;
  localparam logic [30:0] VLIMIT_RESET = 31'h7FFF_FFFF;
  localparam logic [16:0] GAIN_RESET   = 17'd6554;
  localparam logic [30:0] START_RESET  = 31'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAW, CFG_TAU, CFG_TARGET, CFG_SCALE, CFG_CHANGE, CFG_VLIMIT, CFG_GAIN, CFG_START
  } cfg_idx_t;

  typedef struct packed {
    logic start;
    q_t   num;
    q_t   den;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quo;
  } div_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ADV, ST_ADV_W, ST_SL_M, ST_SL_D, ST_SL_W, ST_PUSH,
    ST_WIN_RD, ST_WIN_DAT, ST_WIN_ACC, ST_NUM_D, ST_SPD_D, ST_SPD_W,
    ST_BL_M1, ST_BL_M2, ST_BL_W, ST_E_M, ST_E_D, ST_E_W,
    ST_L1_D, ST_L1_M, ST_L1_W, ST_L2_D, ST_L2_M, ST_L2_D2, ST_L2_M2,
    ST_L3_D, ST_L3_D2, ST_L3_D3, ST_L3_M1, ST_L3_M2, ST_L3_M3, ST_L3_W,
    ST_CL_M, ST_CL_W, ST_RT_D, ST_RT_W, ST_DONE, ST_DWAIT
  } seq_state_t;

  function automatic wide_t ext40(input q_t a);
    return {{(WIDE_W - 32){a[31]}}, a};
  endfunction

  function automatic q_t sat32(input wide_t x);
    q_t r;
    if (x > W_MAX) begin
      r = Q_MAX;
    end else if (x < W_MIN) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/fpfc_if.sv
// Valid/ready channel interfaces for the input steps and the result beats.
// Depends on nothing.
interface fpfc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_position;
  logic        [30:0] time_step;
  logic signed [31:0] current_time;
  logic               first_step;

  modport source (output valid, measured_position, time_step, current_time, first_step,
                  input ready);
  modport sink   (input valid, measured_position, time_step, current_time, first_step,
                  output ready);
endinterface

interface fpfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inlet_velocity;
  logic signed [31:0] velocity_rate;
  logic signed [31:0] base_time;
  logic signed [31:0] speed_estimate;

  modport source (output valid, inlet_velocity, velocity_rate, base_time, speed_estimate,
                  input ready);
  modport sink   (input valid, inlet_velocity, velocity_rate, base_time, speed_estimate,
                  output ready);
endinterface

FILE: rtl/flame_position_flow_controller_core.sv
// Top level of the flame position flow controller: sequencer, state and sample window.
// Depends on fpfc_pkg, fpfc_if, fpfc_mul and fpfc_div.
//
// Each input beat is one control step. The block advances the inlet velocity by the
// stored rate, forms a local front speed, pushes the sample into a 17-entry window and
// then either integrates over the full window or, unless it is a first step, blends
// a running speed estimate. The selected control law gives a new velocity that is
// clamped, and one result beat carries the velocity, its rate, the base time and the
// speed estimate. All values are signed Q16.16. The shared divider is used two to
// eight times per step (depending on the law, on the first-step flag and on whether
// the window is full), and once the window is full each step also walks over the
// window memory. The input side is not ready while a step is in progress; a finished
// result waits in an output register so that the next step can start before it is taken.
// Configuration writes must only be issued while the block is idle. Writing the start
// velocity also reloads the current and prior velocity.
module flame_position_flow_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  fpfc_in_if.sink                          in_ch,
  fpfc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fpfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import fpfc_pkg::*;

  seq_state_t state_r, state_nxt, ret_r, ret_nxt;

  // Configuration registers.
  logic [1:0]  law_r;
  logic [30:0] tau_r, scale_r, chg_r, vlim_r;
  q_t          target_r;
  logic [16:0] gain_r;

  // Persistent controller state.
  q_t                v_now_r, v_prior_r, rate_r, base_r, speed_r, prior_pos_r;
  logic              prior_valid_r;
  logic [FILL_W-1:0] fill_r;

  // Step inputs and scratch registers of the sequencer.
  q_t          coft_r, now_r;
  logic [30:0] dt_r;
  logic        first_r;
  q_t          sl_r, tb_r, e_r, x_r, z_r, w_r, vnew_r;
  q_t          vprev_r, tprev_r, pos_end_r, t_end_r;
  wide_t       acc_r;

  // Sample window, kept as a circular buffer. Entries are only read once the window has
  // been filled completely since reset, so the memories need no reset values.
  q_t                 win_t_mem [WIN_DEPTH];
  q_t                 win_v_mem [WIN_DEPTH];
  q_t                 win_p_mem [WIN_DEPTH];
  logic [WIN_IDX_W-1:0] head_r, rp_r, k_r, head_nxt, rp_dec;
  q_t                 rd_t_r, rd_v_r, rd_p_r;

  // Result register.
  logic out_valid_r;
  q_t   out_vel_r, out_rate_r, out_base_r, out_speed_r;

  // Shared units.
  q_t       mul_a, mul_b, mp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  q_t       q;

  fpfc_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(mp));
  fpfc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign q = div_rsp.quo;

  // Operand views and arithmetic shared by several sequencer steps.
  q_t    dt_q, tau_q, scale_q, chg_q, vlim_q, gain_c, vmax1, half_mp;
  q_t    sl_val, num_val, span_end, e_val, e2, e3, dsv, vt_val, vtt_num, coef;
  q_t    span, vavg, vsum1, vsum3, blend;
  q_t    d_pos, d_tgt, d_end, d_vel, vclamp;
  wide_t vavg_w, d6, lo_w, hi_w, vc_w;
  logic  in_acc;

  assign dt_q     = {1'b0, dt_r};
  assign tau_q    = {1'b0, tau_r};
  assign scale_q  = {1'b0, scale_r};
  assign chg_q    = {1'b0, chg_r};
  assign vlim_q   = {1'b0, vlim_r};
  assign gain_c   = Q_ONE - {15'd0, gain_r};
  assign vmax1    = (v_now_r > Q_ONE) ? v_now_r : Q_ONE;
  assign half_mp  = mp >>> 1;

  assign sl_val   = sat32(((ext40(v_prior_r) + ext40(v_now_r)) >>> 1) - ext40(q));
  assign num_val  = sat32(ext40(sat32(acc_r)) - ext40(q));
  assign span_end = sat32(ext40(now_r) - ext40(t_end_r));
  assign e_val    = sat32(ext40(q) + ext40(speed_r) - ext40(v_now_r));
  assign e2       = sat32(ext40(e_r) <<< 1);
  assign e3       = sat32(ext40(e_r) + (ext40(e_r) <<< 1));
  assign dsv      = sat32(ext40(speed_r) - ext40(v_now_r));
  assign vt_val   = sat32(ext40(x_r) + (ext40(x_r) <<< 1) - (ext40(q) <<< 1));
  assign d6       = ((ext40(q) - ext40(x_r)) <<< 2) + ((ext40(q) - ext40(x_r)) <<< 1);
  assign vtt_num  = sat32(d6);
  assign coef     = sat32(ext40(dt_q) - ext40(q));
  assign vavg_w   = (ext40(vprev_r) + ext40(rd_v_r)) >>> 1;
  assign vavg     = vavg_w[31:0];
  assign span     = sat32(ext40(tprev_r) - ext40(rd_t_r));
  assign vsum1    = sat32(ext40(v_now_r) + ext40(mp));
  assign vsum3    = sat32(ext40(v_now_r) + ext40(w_r) + ext40(mp));
  assign blend    = sat32(ext40(tb_r) + ext40(mp));
  assign d_pos    = sat32(ext40(coft_r) - ext40(prior_pos_r));
  assign d_tgt    = sat32(ext40(target_r) - ext40(coft_r));
  assign d_end    = sat32(ext40(coft_r) - ext40(pos_end_r));
  assign d_vel    = sat32(ext40(vnew_r) - ext40(v_now_r));

  assign head_nxt = (head_r == WIN_IDX_W'(WIN_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rp_dec   = (rp_r == '0) ? WIN_IDX_W'(WIN_DEPTH - 1) : rp_r - 1'b1;

  // Clamp: not below zero, within the change band around the current velocity, and
  // not above the velocity limit. The lower band edge scales with the velocity.
  assign lo_w = ext40(v_now_r) - ext40(mp);
  assign hi_w = ext40(v_now_r) + ext40(chg_q);
  always_comb begin
    vc_w = ext40(vnew_r);
    if (vc_w < 40'sd0) begin
      vc_w = 40'sd0;
    end
    if (vc_w < lo_w) begin
      vc_w = lo_w;
    end
    if (vc_w > hi_w) begin
      vc_w = hi_w;
    end
    if (vc_w > ext40(vlim_q)) begin
      vc_w = ext40(vlim_q);
    end
  end
  assign vclamp = sat32(vc_w);

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Sequencer: next state and the operands offered to the shared units.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mul_a         = 32'sd0;
    mul_b         = 32'sd0;
    div_req.start = 1'b0;
    div_req.num   = 32'sd0;
    div_req.den   = 32'sd0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        mul_a = dt_q; mul_b = rate_r;
        state_nxt = ST_ADV_W;
      end
      ST_ADV_W: state_nxt = ST_SL_M;
      ST_SL_M: begin
        mul_a = dt_q; mul_b = scale_q;
        state_nxt = ST_SL_D;
      end
      ST_SL_D: begin
        div_req = '{start: 1'b1, num: d_pos, den: mp};
        ret_nxt = ST_SL_W; state_nxt = ST_DWAIT;
      end
      ST_SL_W: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (fill_r == '0) begin
          state_nxt = ST_WIN_RD;
        end else if (first_r) begin
          state_nxt = ST_E_M;
        end else begin
          state_nxt = ST_BL_M1;
        end
      end
      ST_WIN_RD: state_nxt = ST_WIN_DAT;
      ST_WIN_DAT: begin
        mul_a = vavg; mul_b = span;
        state_nxt = (k_r == '0) ? ST_WIN_RD : ST_WIN_ACC;
      end
      ST_WIN_ACC: state_nxt = (k_r == WIN_IDX_W'(WINDOW)) ? ST_NUM_D : ST_WIN_RD;
      ST_NUM_D: begin
        div_req = '{start: 1'b1, num: d_end, den: scale_q};
        ret_nxt = ST_SPD_D; state_nxt = ST_DWAIT;
      end
      ST_SPD_D: begin
        div_req = '{start: 1'b1, num: num_val, den: span_end};
        ret_nxt = ST_SPD_W; state_nxt = ST_DWAIT;
      end
      ST_SPD_W: state_nxt = ST_E_M;
      ST_BL_M1: begin
        mul_a = gain_c; mul_b = speed_r;
        state_nxt = ST_BL_M2;
      end
      ST_BL_M2: begin
        mul_a = {15'd0, gain_r}; mul_b = sl_r;
        state_nxt = ST_BL_W;
      end
      ST_BL_W: state_nxt = ST_E_M;
      ST_E_M: begin
        mul_a = scale_q; mul_b = tau_q;
        state_nxt = ST_E_D;
      end
      ST_E_D: begin
        div_req = '{start: 1'b1, num: d_tgt, den: mp};
        ret_nxt = ST_E_W; state_nxt = ST_DWAIT;
      end
      ST_E_W: begin
        unique case (law_r)
          LAW_LINEAR: state_nxt = ST_L1_D;
          LAW_QUAD1:  state_nxt = ST_L2_D;
          LAW_QUAD2:  state_nxt = ST_L3_D;
          default:    state_nxt = ST_CL_M;
        endcase
      end
      ST_L1_D: begin
        div_req = '{start: 1'b1, num: e2, den: tau_q};
        ret_nxt = ST_L1_M; state_nxt = ST_DWAIT;
      end
      ST_L1_M: begin
        mul_a = dt_q; mul_b = q;
        state_nxt = ST_L1_W;
      end
      ST_L1_W: state_nxt = ST_CL_M;
      ST_L2_D: begin
        div_req = '{start: 1'b1, num: e3, den: tau_q};
        ret_nxt = ST_L2_M; state_nxt = ST_DWAIT;
      end
      ST_L2_M: begin
        mul_a = dt_q; mul_b = dt_q;
        state_nxt = ST_L2_D2;
      end
      ST_L2_D2: begin
        div_req = '{start: 1'b1, num: half_mp, den: tau_q};
        ret_nxt = ST_L2_M2; state_nxt = ST_DWAIT;
      end
      ST_L2_M2: begin
        mul_a = coef; mul_b = x_r;
        state_nxt = ST_L1_W;
      end
      ST_L3_D: begin
        div_req = '{start: 1'b1, num: e2, den: tau_q};
        ret_nxt = ST_L3_D2; state_nxt = ST_DWAIT;
      end
      ST_L3_D2: begin
        div_req = '{start: 1'b1, num: dsv, den: tau_q};
        ret_nxt = ST_L3_D3; state_nxt = ST_DWAIT;
      end
      ST_L3_D3: begin
        div_req = '{start: 1'b1, num: vtt_num, den: tau_q};
        ret_nxt = ST_L3_M1; state_nxt = ST_DWAIT;
      end
      ST_L3_M1: begin
        mul_a = dt_q; mul_b = z_r;
        state_nxt = ST_L3_M2;
      end
      ST_L3_M2: begin
        mul_a = dt_q; mul_b = dt_q;
        state_nxt = ST_L3_M3;
      end
      ST_L3_M3: begin
        mul_a = half_mp; mul_b = x_r;
        state_nxt = ST_L3_W;
      end
      ST_L3_W: state_nxt = ST_CL_M;
      ST_CL_M: begin
        mul_a = chg_q; mul_b = vmax1;
        state_nxt = ST_CL_W;
      end
      ST_CL_W: state_nxt = first_r ? ST_DONE : ST_RT_D;
      ST_RT_D: begin
        div_req = '{start: 1'b1, num: d_vel, den: dt_q};
        ret_nxt = ST_RT_W; state_nxt = ST_DWAIT;
      end
      ST_RT_W: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller state, configuration and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      law_r         <= LAW_RESET;
      tau_r         <= TAU_RESET;
      target_r      <= TARGET_RESET;
      scale_r       <= SCALE_RESET;
      chg_r         <= CHANGE_RESET;
      vlim_r        <= VLIMIT_RESET;
      gain_r        <= GAIN_RESET;
      v_now_r       <= {1'b0, START_RESET};
      v_prior_r     <= {1'b0, START_RESET};
      rate_r        <= 32'sd0;
      base_r        <= 32'sd0;
      speed_r       <= 32'sd0;
      prior_pos_r   <= 32'sd0;
      prior_valid_r <= 1'b0;
      fill_r        <= FILL_W'(WIN_DEPTH);
      head_r        <= '0;
      rp_r          <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // A finished step loads the result register as soon as it is free or being taken.
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LAW:    law_r    <= cfg_data[1:0];
          CFG_TAU:    tau_r    <= cfg_data[30:0];
          CFG_TARGET: target_r <= cfg_data;
          CFG_SCALE:  scale_r  <= cfg_data[30:0];
          CFG_CHANGE: chg_r    <= cfg_data[30:0];
          CFG_VLIMIT: vlim_r   <= cfg_data[30:0];
          CFG_GAIN:   gain_r   <= cfg_data[16:0];
          CFG_START: begin
            v_now_r   <= {1'b0, cfg_data[30:0]};
            v_prior_r <= {1'b0, cfg_data[30:0]};
          end
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            v_prior_r <= v_now_r;
            if (!prior_valid_r) begin
              prior_pos_r <= in_ch.measured_position;
            end
            if (in_ch.first_step) begin
              fill_r <= FILL_W'(WIN_DEPTH);
            end
          end
        end
        ST_ADV_W: begin
          if (dt_r != '0) begin
            v_now_r <= vsum1;
          end
        end
        ST_PUSH: begin
          head_r <= head_nxt;
          rp_r   <= head_nxt;
          k_r    <= '0;
          if (fill_r != '0) begin
            fill_r <= fill_r - 1'b1;
          end
        end
        ST_WIN_DAT: begin
          if (k_r == '0) begin
            rp_r <= rp_dec;
            k_r  <= k_r + 1'b1;
          end
        end
        ST_WIN_ACC: begin
          rp_r <= rp_dec;
          k_r  <= k_r + 1'b1;
        end
        ST_SPD_W: speed_r <= q;
        ST_BL_W:  speed_r <= blend;
        ST_RT_W: begin
          rate_r <= q;
          base_r <= now_r;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            prior_pos_r   <= coft_r;
            prior_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Step operands, scratch values and result payload.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          coft_r  <= in_ch.measured_position;
          dt_r    <= in_ch.time_step;
          now_r   <= in_ch.current_time;
          first_r <= in_ch.first_step;
        end
      end
      ST_SL_W: sl_r <= sl_val;
      ST_PUSH: acc_r <= '0;
      ST_WIN_DAT: begin
        vprev_r <= rd_v_r;
        tprev_r <= rd_t_r;
        if (k_r == WIN_IDX_W'(WINDOW)) begin
          pos_end_r <= rd_p_r;
          t_end_r   <= rd_t_r;
        end
      end
      ST_WIN_ACC: acc_r <= acc_r + ext40(mp);
      ST_BL_M2: tb_r <= mp;
      ST_E_W: begin
        e_r    <= e_val;
        vnew_r <= 32'sd0;
      end
      ST_L1_W:  vnew_r <= vsum1;
      ST_L2_M:  x_r <= q;
      ST_L3_D2: x_r <= q;
      ST_L3_D3: z_r <= vt_val;
      ST_L3_M1: x_r <= q;
      ST_L3_M2: w_r <= mp;
      ST_L3_W:  vnew_r <= vsum3;
      ST_CL_W:  vnew_r <= vclamp;
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_vel_r   <= v_now_r;
          out_rate_r  <= rate_r;
          out_base_r  <= base_r;
          out_speed_r <= speed_r;
        end
      end
      default: ;
    endcase
  end

  // Window memories: one write at the new head, one registered read at the walk pointer.
  always_ff @(posedge clk) begin
    if (state_r == ST_PUSH) begin
      win_t_mem[head_nxt] <= now_r;
      win_v_mem[head_nxt] <= v_now_r;
      win_p_mem[head_nxt] <= coft_r;
    end
    rd_t_r <= win_t_mem[rp_r];
    rd_v_r <= win_v_mem[rp_r];
    rd_p_r <= win_p_mem[rp_r];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.inlet_velocity = out_vel_r;
  assign out_ch.velocity_rate  = out_rate_r;
  assign out_ch.base_time      = out_base_r;
  assign out_ch.speed_estimate = out_speed_r;
endmodule

FILE: rtl/fpfc_mul.sv
// Shared Q16.16 multiplier with floor rounding, saturation and a registered result.
// Depends on fpfc_pkg.
module fpfc_mul (
  input  logic          clk,
  input  fpfc_pkg::q_t  op_a,
  input  fpfc_pkg::q_t  op_b,
  output fpfc_pkg::q_t  prod
);
  import fpfc_pkg::*;

  logic signed [63:0] full;
  logic signed [47:0] shr;
  q_t                 prod_r;

  assign full = op_a * op_b;
  assign shr  = full[63:Q_FRAC];

  always_ff @(posedge clk) begin
    if (shr > 48'sh0000_7FFF_FFFF) begin
      prod_r <= Q_MAX;
    end else if (shr < -48'sd2147483648) begin
      prod_r <= Q_MIN;
    end else begin
      prod_r <= shr[31:0];
    end
  end

  assign prod = prod_r;
endmodule

FILE: rtl/fpfc_div.sv
// Shared Q16.16 divider, one quotient bit per cycle, truncating and saturating.
// Depends on fpfc_pkg.
module fpfc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fpfc_pkg::div_req_t req,
  output fpfc_pkg::div_rsp_t rsp
);
  import fpfc_pkg::*;

  logic                 run_r, fin_r, done_r, neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_STEPS-1:0] dvd_r;
  logic [31:0]          dvs_r, rem_r;
  q_t                   quo_r;
  logic [31:0]          mag_a, mag_b;
  logic [32:0]          rem_sh, rem_sub;
  logic                 fits;
  logic                 den_zero;
  logic                 last_step;

  assign mag_a     = req.num[31] ? (~req.num + 32'd1) : req.num;
  assign mag_b     = req.den[31] ? (~req.den + 32'd1) : req.den;
  assign den_zero  = (req.den == 32'sd0);
  assign rem_sh    = {rem_r, dvd_r[DIV_STEPS-1]};
  assign rem_sub   = rem_sh - {1'b0, dvs_r};
  assign fits      = (rem_sh >= {1'b0, dvs_r});
  assign last_step = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= (req.start && den_zero) || (!req.start && !run_r && fin_r);
      fin_r  <= !req.start && run_r && last_step;
      if (req.start) begin
        if (!den_zero) begin
          run_r <= 1'b1;
          cnt_r <= '0;
        end
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.num[31] ^ req.den[31];
      dvd_r <= {mag_a, {Q_FRAC{1'b0}}};
      dvs_r <= mag_b;
      rem_r <= '0;
      if (den_zero) begin
        if (req.num == 32'sd0) begin
          quo_r <= 32'sd0;
        end else if (req.num[31]) begin
          quo_r <= Q_MIN;
        end else begin
          quo_r <= Q_MAX;
        end
      end
    end else if (run_r) begin
      rem_r <= fits ? rem_sub[31:0] : rem_sh[31:0];
      dvd_r <= {dvd_r[DIV_STEPS-2:0], fits};
    end else if (fin_r) begin
      if (!neg_r) begin
        quo_r <= (dvd_r > DIV_STEPS'(32'h7FFF_FFFF)) ? Q_MAX : dvd_r[31:0];
      end else begin
        quo_r <= (dvd_r > DIV_STEPS'(32'h8000_0000)) ? Q_MIN : (~dvd_r[31:0] + 32'd1);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule
